@@ src/bals_pkg.sv @@
package bals_pkg;

  // default sizes
  localparam int MAX_FIELD_BITS_DEF   = 64;
  localparam int LENGTH_MAX_BYTES_DEF = 4;

  // payload widths
  localparam int OP_W    = 2;
  localparam int VALUE_W = 64;
  localparam int COUNT_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE_BITS   = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_LENGTH = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH        = 2'd2;

  // expandable length format
  localparam int GROUP_BITS = 7;

endpackage

@@ src/bit_and_length_serializer.sv @@
// Bit and length serializer: turns commands into an MSB-first byte stream.
// Input channel (in_valid / in_stall): one command beat holds operation,
// value, bit_count and compact. Output channel (out_valid / out_stall): one
// byte beat with out_byte, range_error and last; last marks the final byte
// caused by a command, and commands that cause no byte produce no beat.
// Write-bits appends the low bit_count bits of value to a partial byte and
// emits every byte that fills; flush emits the pending partial byte padded
// with zeros; write-length emits 7-bit groups with a continuation flag, or a
// single error beat when the value does not fit.
// A command is taken only while the block is idle. One shared left shifter
// over a working register aligns each field and steps through it: write-bits
// steps once per filled byte or partial fill, write-length once per group,
// and flush and the error beat each emit their single beat directly.
// The first byte comes from the sequencer state entered at the accepting
// edge and reaches the output through the output register.
// The output register holds its beat while out_stall is high, and the
// sequencer waits whenever it needs to emit into a stalled output register.
// Synchronous reset clears the partial byte, the pending bit count, the
// sequencer and the output valid.
module bit_and_length_serializer
  import bals_pkg::*;
#(
  parameter int MAX_FIELD_BITS   = MAX_FIELD_BITS_DEF,
  parameter int LENGTH_MAX_BYTES = LENGTH_MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    operation,
  input  logic [VALUE_W-1:0] value,
  input  logic [COUNT_W-1:0] bit_count,
  input  logic               compact,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               range_error,
  output logic               last
);

  localparam int LEN_W = GROUP_BITS * LENGTH_MAX_BYTES;
  localparam int SW    = (MAX_FIELD_BITS > LEN_W) ? MAX_FIELD_BITS : LEN_W;
  localparam int SA_W  = $clog2(SW + 1);
  localparam int CW    = $clog2(MAX_FIELD_BITS + 1);
  localparam int NB_W  = $clog2(LENGTH_MAX_BYTES + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BITS  = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  logic [2:0]      state, state_next;
  logic [SW-1:0]   shreg, shreg_next;
  logic [CW-1:0]   rem, rem_next;
  logic [NB_W-1:0] cnt, cnt_next;
  logic [7:0]      partial, partial_next;
  logic [2:0]      pending, pending_next;

  logic [SW-1:0]   sh_src, sh_out;
  logic [SA_W-1:0] sh_amt;

  logic            can_emit;
  logic            emit_now;
  logic [7:0]      e_byte;
  logic            e_err;
  logic            e_last;

  logic [CW-1:0]   c_sat;
  logic [LEN_W-1:0] len_val;
  logic            len_err;
  logic [NB_W-1:0] nb_fit, nb;

  logic [3:0]      avail, take, pend_sum;
  logic [CW-1:0]   rem_after;
  logic [7:0]      fill_byte;

  // shared shifter
  assign sh_out = sh_src << sh_amt;

  assign in_stall = (state != ST_IDLE);
  assign can_emit = !out_valid || !out_stall;

  // command decode: saturated bit count, length range and group count
  assign c_sat   = (bit_count > COUNT_W'(MAX_FIELD_BITS)) ? CW'(MAX_FIELD_BITS)
                                                         : CW'(bit_count);
  assign len_val = value[LEN_W-1:0];
  assign len_err = (value >> LEN_W) != '0;

  always_comb begin
    nb_fit = NB_W'(1);
    for (int g = 1; g < LENGTH_MAX_BYTES; g++) begin
      if ((len_val >> (GROUP_BITS * g)) != '0) nb_fit = NB_W'(g + 1);
    end
  end

  assign nb = compact ? nb_fit : NB_W'(LENGTH_MAX_BYTES);

  // one bit-fill step: as many bits as fit in the partial byte
  assign avail     = 4'd8 - {1'b0, pending};
  assign take      = (rem < CW'(avail)) ? rem[3:0] : avail;
  assign pend_sum  = {1'b0, pending} + take;
  assign rem_after = rem - CW'(take);
  assign fill_byte = partial | (shreg[SW-1 -: 8] >> pending);

  // sequencer
  always_comb begin
    state_next   = state;
    shreg_next   = shreg;
    rem_next     = rem;
    cnt_next     = cnt;
    partial_next = partial;
    pending_next = pending;
    sh_src       = shreg;
    sh_amt       = '0;
    emit_now     = 1'b0;
    e_byte       = fill_byte;
    e_err        = 1'b0;
    e_last       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (operation)
            OP_WRITE_BITS: begin
              // left-align the field in the working register
              sh_src     = SW'(value[MAX_FIELD_BITS-1:0]);
              sh_amt     = SA_W'(SW) - SA_W'(c_sat);
              shreg_next = sh_out;
              rem_next   = c_sat;
              if (c_sat != '0) state_next = ST_BITS;
            end
            OP_WRITE_LENGTH: begin
              if (len_err) begin
                state_next = ST_ERR;
              end else begin
                sh_src     = SW'(len_val);
                sh_amt     = SA_W'(SW) - SA_W'(nb) * SA_W'(GROUP_BITS);
                shreg_next = sh_out;
                cnt_next   = nb;
                state_next = ST_LEN;
              end
            end
            OP_FLUSH: begin
              if (pending != '0) state_next = ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end

      ST_BITS: begin
        if (!pend_sum[3] || can_emit) begin
          sh_amt     = SA_W'(take);
          shreg_next = sh_out;
          rem_next   = rem_after;
          emit_now   = pend_sum[3];
          e_byte     = fill_byte;
          // once a byte is out the pending count is zero, so another byte
          // follows only if eight more bits remain
          e_last     = rem_after < CW'(8);
          if (pend_sum[3]) begin
            partial_next = '0;
            pending_next = '0;
          end else begin
            partial_next = fill_byte;
            pending_next = pend_sum[2:0];
          end
          if (rem_after == '0) state_next = ST_IDLE;
        end
      end

      ST_LEN: begin
        if (can_emit) begin
          sh_amt     = SA_W'(GROUP_BITS);
          shreg_next = sh_out;
          cnt_next   = cnt - NB_W'(1);
          emit_now   = 1'b1;
          e_byte     = {cnt != NB_W'(1), shreg[SW-1 -: GROUP_BITS]};
          e_last     = (cnt == NB_W'(1));
          if (cnt == NB_W'(1)) state_next = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        if (can_emit) begin
          emit_now     = 1'b1;
          e_byte       = partial;
          e_last       = 1'b1;
          partial_next = '0;
          pending_next = '0;
          state_next   = ST_IDLE;
        end
      end

      ST_ERR: begin
        if (can_emit) begin
          emit_now   = 1'b1;
          e_byte     = '0;
          e_err      = 1'b1;
          e_last     = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control and bit buffer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      partial <= '0;
      pending <= '0;
    end else begin
      state   <= state_next;
      partial <= partial_next;
      pending <= pending_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    shreg <= shreg_next;
    rem   <= rem_next;
    cnt   <= cnt_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_emit) begin
      out_valid <= emit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit && emit_now) begin
      out_byte    <= e_byte;
      range_error <= e_err;
      last        <= e_last;
    end
  end

endmodule

@@ src/bals_checker.sv @@
module bals_checker
  import bals_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [OP_W-1:0]    operation,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         out_byte,
  input logic               range_error,
  input logic               last
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(range_error) && $stable(last))
    else $error("stalled output beat changed");

  // an error beat carries a zero byte and ends its command
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> out_byte == 8'd0 && last)
    else $error("malformed range error beat");

  // a length command always produces at least one beat, so the block is busy
  a_len_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation == OP_WRITE_LENGTH |=> in_stall)
    else $error("length command did not occupy the sequencer");

  // reset leaves no beat on the output
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bit_and_length_serializer bals_checker u_bals_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .operation   (operation),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .range_error (range_error),
  .last        (last)
);

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb
  import bals_pkg::*;
();

  // reserved operation code, the block ignores it
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  // expandable length bounds
  localparam logic [31:0] LEN_LIMIT =
    (LENGTH_MAX_BYTES_DEF >= 4) ? 32'h0FFF_FFFF
                                : (32'd1 << (GROUP_BITS * LENGTH_MAX_BYTES_DEF)) - 32'd1;
  localparam logic [31:0] ONE_GROUP_MAX   = 32'h7F;
  localparam logic [31:0] TWO_GROUP_MAX   = 32'h3FFF;
  localparam logic [31:0] THREE_GROUP_MAX = 32'h1F_FFFF;
  localparam logic [7:0]  CONT_FLAG       = 8'h80;

  localparam int RANDOM_PER_PHASE = 88;
  localparam int MAX_PRINTED      = 20;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               compact;
    bit                 typed;
    int                 n_typed;
    logic [63:0]        typed_bytes;
    logic               typed_err;
  } cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       err;
    logic       is_last;
  } beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    operation = OP_WRITE_BITS;
  logic [VALUE_W-1:0] value = '0;
  logic [COUNT_W-1:0] bit_count = '0;
  logic               compact = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte;
  logic               range_error;
  logic               last;

  // serializer predictor state
  logic [7:0] held_byte = '0;
  int         held_bits = 0;

  beat_t pending_beats[$];
  beat_t fresh_beats[$];
  beat_t head_beat;
  cmd_t  directed_cmds[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int beats_seen = 0;
  int errors_seen = 0;
  int op_count[4] = '{0, 0, 0, 0};

  bit_and_length_serializer i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .value       (value),
    .bit_count   (bit_count),
    .compact     (compact),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .range_error (range_error),
    .last        (last)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTED) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
    errors++;
  endtask

  function automatic void push_fresh(input logic [7:0] data, input logic err);
    beat_t b;
    b.data = data;
    b.err = err;
    b.is_last = 1'b0;
    fresh_beats.push_back(b);
  endfunction

  // predict the byte beats of one command and advance the bit buffer
  function automatic void serialize_cmd(input cmd_t c);
    int nbits;
    int ngroups;
    logic [31:0] len;
    fresh_beats.delete();
    case (c.op)
      OP_WRITE_BITS: begin
        nbits = (int'(c.count) > MAX_FIELD_BITS_DEF) ? MAX_FIELD_BITS_DEF : int'(c.count);
        for (int i = nbits - 1; i >= 0; i--) begin
          held_byte[7 - held_bits] = c.value[i];
          held_bits++;
          if (held_bits == 8) begin
            push_fresh(held_byte, 1'b0);
            held_byte = '0;
            held_bits = 0;
          end
        end
      end
      OP_WRITE_LENGTH: begin
        if (c.value > 64'(LEN_LIMIT)) begin
          push_fresh(8'h00, 1'b1);
        end else begin
          len = c.value[31:0];
          if (!c.compact) ngroups = 4;
          else if (len <= ONE_GROUP_MAX) ngroups = 1;
          else if (len <= TWO_GROUP_MAX) ngroups = 2;
          else if (len <= THREE_GROUP_MAX) ngroups = 3;
          else ngroups = 4;
          if (ngroups > LENGTH_MAX_BYTES_DEF) ngroups = LENGTH_MAX_BYTES_DEF;
          // most significant group first, continuation flag on all but the last
          for (int i = ngroups - 1; i >= 0; i--) begin
            push_fresh({1'b0, len[i*GROUP_BITS +: GROUP_BITS]} | ((i > 0) ? CONT_FLAG : 8'h00),
                       1'b0);
          end
        end
      end
      OP_FLUSH: begin
        if (held_bits > 0) begin
          push_fresh(held_byte, 1'b0);
          held_byte = '0;
          held_bits = 0;
        end
      end
      default: begin
      end
    endcase
    if (fresh_beats.size() > 0) fresh_beats[fresh_beats.size()-1].is_last = 1'b1;
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op, input logic [63:0] val,
                                  input logic [COUNT_W-1:0] cnt, input logic cmp,
                                  input bit typed, input int n, input logic [63:0] bytes,
                                  input logic err);
    cmd_t c;
    c.op = op;
    c.value = val;
    c.count = cnt;
    c.compact = cmp;
    c.typed = typed;
    c.n_typed = n;
    c.typed_bytes = bytes;
    c.typed_err = err;
    directed_cmds.push_back(c);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    c.typed = 0;
    c.n_typed = 0;
    c.typed_bytes = '0;
    c.typed_err = 1'b0;
    c.compact = 1'($urandom_range(1));
    c.value = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 5) c.count = '0;
    else if (pick < 70) c.count = COUNT_W'($urandom_range(12, 1));
    else if (pick < 90) c.count = COUNT_W'($urandom_range(64, 13));
    else c.count = COUNT_W'($urandom_range(127, 65));
    pick = $urandom_range(99);
    if (pick < 50) begin
      c.op = OP_WRITE_BITS;
      pick = $urandom_range(19);
      if (pick == 0) c.value = '1;
      else if (pick == 1) c.value = '0;
    end else if (pick < 78) begin
      c.op = OP_WRITE_LENGTH;
      // spread lengths over every group count, the limit and beyond
      case ($urandom_range(9))
        0, 1: c.value = 64'($urandom_range(ONE_GROUP_MAX, 0));
        2, 3: c.value = 64'($urandom_range(TWO_GROUP_MAX, ONE_GROUP_MAX + 1));
        4, 5: c.value = 64'($urandom_range(THREE_GROUP_MAX, TWO_GROUP_MAX + 1));
        6, 7: c.value = 64'($urandom_range(LEN_LIMIT, THREE_GROUP_MAX + 1));
        8:    c.value = 64'(LEN_LIMIT) + 64'($urandom_range(1));
        default: begin
        end
      endcase
    end else if (pick < 95) begin
      c.op = OP_FLUSH;
    end else begin
      c.op = OP_RESERVED;
    end
    return c;
  endfunction

  // drive one command beat and record what it must produce
  task automatic send_cmd(input cmd_t c);
    beat_t b;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= c.op;
    value     <= c.value;
    bit_count <= c.count;
    compact   <= c.compact;
    do @(posedge clk); while (in_stall);
    serialize_cmd(c);
    op_count[c.op]++;
    if (c.typed) begin
      for (int k = 0; k < c.n_typed; k++) begin
        b.data = c.typed_bytes[8*(c.n_typed-1-k) +: 8];
        b.err = c.typed_err;
        b.is_last = (k == c.n_typed - 1);
        pending_beats.push_back(b);
      end
    end else begin
      foreach (fresh_beats[k]) pending_beats.push_back(fresh_beats[k]);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // compare each output beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte %02h err %b last %b",
                                  out_byte, range_error, last));
      end else begin
        head_beat = pending_beats.pop_front();
        beats_seen++;
        if (range_error === 1'b1) errors_seen++;
        if (out_byte !== head_beat.data)
          report_mismatch($sformatf("out_byte %02h, wanted %02h", out_byte, head_beat.data));
        if (range_error !== head_beat.err)
          report_mismatch($sformatf("range_error %b, wanted %b", range_error, head_beat.err));
        if (last !== head_beat.is_last)
          report_mismatch($sformatf("last %b, wanted %b", last, head_beat.is_last));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: length extremes, errors, ignored commands, bit packing
    add_row(OP_WRITE_LENGTH, 64'h0, 7'd0, 1'b1, 1, 1, 64'h00, 1'b0);
    add_row(OP_WRITE_LENGTH, 64'h7F, 7'd0, 1'b1, 1, 1, 64'h7F, 1'b0);
    add_row(OP_WRITE_LENGTH, 64'h80, 7'd0, 1'b1, 1, 2, 64'h8100, 1'b0);
    add_row(OP_WRITE_LENGTH, 64'h3FFF, 7'd0, 1'b1, 1, 2, 64'hFF7F, 1'b0);
    add_row(OP_WRITE_LENGTH, 64'h4000, 7'd0, 1'b1, 1, 3, 64'h818000, 1'b0);
    add_row(OP_WRITE_LENGTH, 64'h1F_FFFF, 7'd0, 1'b1, 1, 3, 64'hFFFF7F, 1'b0);
    add_row(OP_WRITE_LENGTH, 64'h20_0000, 7'd0, 1'b1, 1, 4, 64'h81808000, 1'b0);
    add_row(OP_WRITE_LENGTH, 64'h0FFF_FFFF, 7'd0, 1'b1, 1, 4, 64'hFFFFFF7F, 1'b0);
    add_row(OP_WRITE_LENGTH, 64'h0, 7'd0, 1'b0, 1, 4, 64'h80808000, 1'b0);
    add_row(OP_WRITE_LENGTH, 64'h0FFF_FFFF, 7'd0, 1'b0, 1, 4, 64'hFFFFFF7F, 1'b0);
    add_row(OP_WRITE_LENGTH, 64'h1000_0000, 7'd0, 1'b1, 1, 1, 64'h00, 1'b1);
    add_row(OP_WRITE_LENGTH, '1, 7'd127, 1'b0, 1, 1, 64'h00, 1'b1);
    add_row(OP_WRITE_BITS, '1, 7'd0, 1'b1, 1, 0, 64'h0, 1'b0);
    add_row(OP_FLUSH, '1, 7'd127, 1'b1, 1, 0, 64'h0, 1'b0);
    add_row(OP_RESERVED, '1, 7'd127, 1'b1, 1, 0, 64'h0, 1'b0);
    add_row(OP_WRITE_BITS, 64'hFFFF_FFFF_FFFF_FFA5, 7'd8, 1'b0, 1, 1, 64'hA5, 1'b0);
    add_row(OP_WRITE_BITS, '1, 7'd64, 1'b0, 1, 8, '1, 1'b0);
    add_row(OP_WRITE_BITS, 64'h0123_4567_89AB_CDEF, 7'd127, 1'b1, 1, 8,
            64'h0123_4567_89AB_CDEF, 1'b0);
    add_row(OP_WRITE_BITS, 64'h5, 7'd3, 1'b0, 0, 0, 64'h0, 1'b0);
    add_row(OP_WRITE_LENGTH, 64'h55, 7'd0, 1'b1, 1, 1, 64'h55, 1'b0);
    add_row(OP_FLUSH, 64'h0, 7'd0, 1'b0, 1, 1, 64'hA0, 1'b0);
    add_row(OP_WRITE_BITS, 64'h1, 7'd1, 1'b0, 0, 0, 64'h0, 1'b0);
    add_row(OP_WRITE_BITS, {$urandom, $urandom}, 7'd13, 1'b0, 0, 0, 64'h0, 1'b0);
    add_row(OP_WRITE_BITS, {$urandom, $urandom}, 7'd65, 1'b1, 0, 0, 64'h0, 1'b0);
    add_row(OP_FLUSH, 64'h0, 7'd0, 1'b0, 0, 0, 64'h0, 1'b0);

    foreach (directed_cmds[i]) send_cmd(directed_cmds[i]);

    // random commands under each idling and stall pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_cmd(random_cmd());
    end

    // drain outstanding beats, then watch for strays
    in_valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d write-bits, %0d length, %0d flush and %0d reserved commands",
             op_count[OP_WRITE_BITS], op_count[OP_WRITE_LENGTH], op_count[OP_FLUSH],
             op_count[OP_RESERVED]);
    $display("checked %0d output beats, %0d of them range errors, %0d mismatches",
             beats_seen, errors_seen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #6_000_000;
    $display("run timed out with %0d beats outstanding", pending_beats.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/bals_pkg.sv
src/bit_and_length_serializer.sv
src/bals_checker.sv
dv/tb.sv
